[rtl/two_pass_counting_radix_sort_defines.svh]
// assertion macros used by the checker file
`ifndef TWO_PASS_COUNTING_RADIX_SORT_DEFINES_SVH
`define TWO_PASS_COUNTING_RADIX_SORT_DEFINES_SVH

// condition and consequence in the same cycle
`define TPCRS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpcrs assertion failed");

// consequence in the cycle after the condition
`define TPCRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpcrs assertion failed");

`endif

[rtl/tpcrs_pkg.sv]
`timescale 1ns / 1ps

package tpcrs_pkg;

   localparam int KEY_BITS         = 10;
   localparam int KEY_RANGE        = 1 << KEY_BITS;
   localparam int ITEM_BITS        = 2 * KEY_BITS;
   localparam int DEFAULT_CAPACITY = 1024;

   localparam logic [KEY_BITS-1:0] KEY_LIMIT_RESET = '1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [2:0] {
      STATUS_LOADED     = 3'd0,
      STATUS_FULL       = 3'd1,
      STATUS_OVER_LIMIT = 3'd2,
      STATUS_READ_OK    = 3'd3,
      STATUS_EMPTY      = 3'd4
   } status_type;

   typedef struct packed {
      logic                action;
      logic [KEY_BITS-1:0] first_vertex;
      logic [KEY_BITS-1:0] second_vertex;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] first_vertex_out;
      logic [KEY_BITS-1:0] second_vertex_out;
      logic                last_item;
   } rsp_type;

endpackage

[rtl/two_pass_counting_radix_sort.sv]
`timescale 1ns / 1ps
// Batch sorter for vertex pairs, ascending by {first_vertex, second_vertex}.
// req channel: action load appends one pair, action read returns the next
// sorted pair; every request gives exactly one rsp transfer with a status.
// csr channel: one write sets key_limit; loads with a half above it are
// rejected. csr_ready is always high.
// A load answers through the pending register and then the output register
// (one request in flight). A read of an already sorted batch steps through
// fetch, deliver and push. The first read after loads sorts first: two passes,
// each a histogram clear over the key range, a count stream over the batch, a
// prefix sweep over the key range and a scatter stream, bound by the single
// read and write port of the histogram memory.
// Reset clears counts and flags; item memory holds garbage until loaded.
// A stalled rsp holds in its output register while the next request is
// taken; that request waits for the register before it answers.
module two_pass_counting_radix_sort
   import tpcrs_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [KEY_BITS-1:0] csr_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = IW + 1;
   localparam int JW = KEY_BITS + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_COUNT, S_PREFIX, S_SCATTER, S_FETCH, S_DELIVER, S_PUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rp_ff, rp_in;
   logic                sorted_ff, sorted_in;
   logic                pass_ff, pass_in;
   logic [KEY_BITS-1:0] key_limit_ff, key_limit_in;
   logic [CW-1:0]       i_ff, i_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic [ITEM_BITS-1:0] s2_word_ff, s2_word_in;
   logic [KEY_BITS-1:0] s2_key_ff, s2_key_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [KEY_BITS-1:0] fwd_key_ff, fwd_key_in;
   logic [CW-1:0]       fwd_val_ff, fwd_val_in;
   logic [JW-1:0]       j_ff, j_in;
   logic                p_valid_ff, p_valid_in;
   logic [KEY_BITS-1:0] p_key_ff, p_key_in;
   logic [CW-1:0]       run_ff, run_in;
   rsp_type             pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                 data_we;
   logic [AW-1:0]        data_wr_addr;
   logic [ITEM_BITS-1:0] data_wr_data;
   logic [AW-1:0]        data_rd_addr;
   logic [ITEM_BITS-1:0] data_rd_data;
   logic                 hist_we;
   logic [KEY_BITS-1:0]  hist_wr_addr;
   logic [CW-1:0]        hist_wr_data;
   logic [KEY_BITS-1:0]  hist_rd_addr;
   logic [CW-1:0]        hist_rd_data;

   logic [KEY_BITS-1:0]  s1_key;
   logic [CW-1:0]        s2_cnt;
   logic                 out_free;

   // bank 0 holds the batch, bank 1 the copy between the passes
   tpcrs_ram #(.WIDTH(ITEM_BITS), .DEPTH(2 ** AW)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_data)
   );

   tpcrs_ram #(.WIDTH(CW), .DEPTH(KEY_RANGE)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   assign s1_key = pass_ff ? data_rd_data[ITEM_BITS-1:KEY_BITS] : data_rd_data[KEY_BITS-1:0];
   // the write made while this read was issued is not yet seen by the read that lands now
   assign s2_cnt = (fwd_valid_ff && fwd_key_ff == s2_key_ff) ? fwd_val_ff : hist_rd_data;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      sorted_in    = sorted_ff;
      pass_in      = pass_ff;
      key_limit_in = key_limit_ff;
      i_in         = i_ff;
      s1_valid_in  = 1'b0;
      s2_valid_in  = 1'b0;
      s2_word_in   = s2_word_ff;
      s2_key_in    = s2_key_ff;
      fwd_valid_in = 1'b0;
      fwd_key_in   = fwd_key_ff;
      fwd_val_in   = fwd_val_ff;
      j_in         = j_ff;
      p_valid_in   = 1'b0;
      p_key_in     = p_key_ff;
      run_in       = run_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      data_we      = 1'b0;
      data_wr_addr = '0;
      data_wr_data = '0;
      data_rd_addr = '0;
      hist_we      = 1'b0;
      hist_wr_addr = '0;
      hist_wr_data = '0;
      hist_rd_addr = '0;

      if (csr_valid) begin
         key_limit_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_in = '0;
               if (req_data.action == ACT_LOAD) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     pend_in.status = STATUS_FULL;
                  end else if (req_data.first_vertex > key_limit_ff ||
                               req_data.second_vertex > key_limit_ff) begin
                     pend_in.status = STATUS_OVER_LIMIT;
                  end else begin
                     data_we        = 1'b1;
                     data_wr_addr   = {1'b0, count_ff[IW-1:0]};
                     data_wr_data   = {req_data.first_vertex, req_data.second_vertex};
                     count_in       = count_ff + CW'(1);
                     sorted_in      = 1'b0;
                     rp_in          = '0;
                     pend_in.status = STATUS_LOADED;
                  end
                  state_in = S_PUSH;
               end else if (count_ff == '0) begin
                  pend_in.status = STATUS_EMPTY;
                  state_in       = S_PUSH;
               end else if (sorted_ff) begin
                  state_in = S_FETCH;
               end else begin
                  pass_in  = 1'b0;
                  j_in     = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            hist_we      = 1'b1;
            hist_wr_addr = j_ff[KEY_BITS-1:0];
            hist_wr_data = '0;
            if (j_ff == JW'(KEY_RANGE - 1)) begin
               i_in     = '0;
               state_in = S_COUNT;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         S_COUNT, S_SCATTER: begin
            // read item, then histogram, then increment and write back; scatter copies the item
            if (i_ff != count_ff) begin
               data_rd_addr = {pass_ff, i_ff[IW-1:0]};
               s1_valid_in  = 1'b1;
               i_in         = i_ff + CW'(1);
            end
            if (s1_valid_ff) begin
               hist_rd_addr = s1_key;
               s2_valid_in  = 1'b1;
               s2_word_in   = data_rd_data;
               s2_key_in    = s1_key;
            end
            if (s2_valid_ff) begin
               hist_we      = 1'b1;
               hist_wr_addr = s2_key_ff;
               hist_wr_data = s2_cnt + CW'(1);
               fwd_valid_in = 1'b1;
               fwd_key_in   = s2_key_ff;
               fwd_val_in   = s2_cnt + CW'(1);
               if (state_ff == S_SCATTER) begin
                  data_we      = 1'b1;
                  data_wr_addr = {~pass_ff, s2_cnt[IW-1:0]};
                  data_wr_data = s2_word_ff;
               end
            end
            if (i_ff == count_ff && !s1_valid_ff && !s2_valid_ff) begin
               j_in = '0;
               if (state_ff == S_COUNT) begin
                  run_in   = '0;
                  state_in = S_PREFIX;
               end else if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  sorted_in = 1'b1;
                  rp_in     = '0;
                  state_in  = S_FETCH;
               end
            end
         end
         S_PREFIX: begin
            // exclusive running sum, each entry written back in the cycle after its read is issued
            if (j_ff != JW'(KEY_RANGE)) begin
               hist_rd_addr = j_ff[KEY_BITS-1:0];
               p_valid_in   = 1'b1;
               p_key_in     = j_ff[KEY_BITS-1:0];
               j_in         = j_ff + JW'(1);
            end
            if (p_valid_ff) begin
               hist_we      = 1'b1;
               hist_wr_addr = p_key_ff;
               hist_wr_data = run_ff;
               run_in       = run_ff + hist_rd_data;
            end
            if (j_ff == JW'(KEY_RANGE) && !p_valid_ff) begin
               i_in     = '0;
               state_in = S_SCATTER;
            end
         end
         S_FETCH: begin
            data_rd_addr = {1'b0, rp_ff[IW-1:0]};
            state_in     = S_DELIVER;
         end
         S_DELIVER: begin
            pend_in.status            = STATUS_READ_OK;
            pend_in.first_vertex_out  = data_rd_data[ITEM_BITS-1:KEY_BITS];
            pend_in.second_vertex_out = data_rd_data[KEY_BITS-1:0];
            if (rp_ff + CW'(1) == count_ff) begin
               pend_in.last_item = 1'b1;
               count_in          = '0;
               rp_in             = '0;
               sorted_in         = 1'b0;
            end else begin
               pend_in.last_item = 1'b0;
               rp_in             = rp_ff + CW'(1);
            end
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         pass_ff      <= 1'b0;
         key_limit_ff <= KEY_LIMIT_RESET;
         i_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         j_ff         <= '0;
         p_valid_ff   <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         pass_ff      <= pass_in;
         key_limit_ff <= key_limit_in;
         i_ff         <= i_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         j_ff         <= j_in;
         p_valid_ff   <= p_valid_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s2_word_ff  <= s2_word_in;
      s2_key_ff   <= s2_key_in;
      fwd_key_ff  <= fwd_key_in;
      fwd_val_ff  <= fwd_val_in;
      p_key_ff    <= p_key_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

[rtl/tpcrs_ram.sv]
`timescale 1ns / 1ps

module tpcrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tpcrs_checker.sv]
`timescale 1ns / 1ps
`include "two_pass_counting_radix_sort_defines.svh"

module tpcrs_checker
   import tpcrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic pair_answer;
   logic pair_clear;

   assign pair_answer = (rsp_data.status == STATUS_READ_OK);
   assign pair_clear  = rsp_data.first_vertex_out == '0 && rsp_data.second_vertex_out == '0 &&
                        !rsp_data.last_item;

   `TPCRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TPCRS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // a transfer starts work, so req_ready is low right after it
   `TPCRS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TPCRS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   // only a read answer carries a pair
   `TPCRS_ASSERT_NOW(a_plain_status, clock, reset, rsp_valid && !pair_answer, pair_clear)

endmodule

bind two_pass_counting_radix_sort tpcrs_checker u_tpcrs_checker (.*);

[bench/tb_two_pass_counting_radix_sort.sv]
`timescale 1ns / 1ps

module tb_two_pass_counting_radix_sort;
   import tpcrs_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 380;
   localparam int TAIL_READS   = 16;
   localparam int QUIET_LIMIT  = 50000;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_SPACING = 1100;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [KEY_BITS-1:0] csr_data = '0;

   // mirror of the sorter
   logic [ITEM_BITS-1:0] batch_items [CAPACITY];
   int                   batch_count = 0;
   int                   read_index = 0;
   bit                   batch_sorted = 1'b0;
   logic [KEY_BITS-1:0]  limit_now = KEY_LIMIT_RESET;

   // stimulus side bookkeeping, tracks what the sorter will hold
   int                  plan_count = 0;
   int                  plan_ptr = 0;
   logic [KEY_BITS-1:0] plan_limit = KEY_LIMIT_RESET;
   int                  items_queued = 0;

   req_type queued_requests [$];
   rsp_type awaited_answers [$];

   bit                req_taken = 1'b0;
   int                gap_left = 0;
   int                burst_left = 0;
   int                hold_left = 0;
   int                next_hold_at = 400;
   int                mode_left = 0;
   ready_pattern_type ready_mode = READY_ALWAYS;
   int                quiet_cycles = 0;

   int errors = 0;
   int answers_seen = 0;
   int loads_stored = 0;
   int full_rejects = 0;
   int limit_rejects = 0;
   int empty_reads = 0;
   int sorts_done = 0;
   int batches_drained = 0;
   int holds_done = 0;
   int csr_writes = 0;

   two_pass_counting_radix_sort #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type sorter_answer(input req_type r);
      rsp_type              a;
      logic [ITEM_BITS-1:0] v;
      int                   i;
      int                   j;
      a = '0;
      if (r.action == ACT_LOAD) begin
         if (batch_count >= CAPACITY) begin
            a.status = STATUS_FULL;
            full_rejects++;
         end else if (r.first_vertex > limit_now || r.second_vertex > limit_now) begin
            a.status = STATUS_OVER_LIMIT;
            limit_rejects++;
         end else begin
            batch_items[batch_count] = {r.first_vertex, r.second_vertex};
            batch_count++;
            batch_sorted = 1'b0;
            read_index = 0;
            a.status = STATUS_LOADED;
            loads_stored++;
         end
      end else if (batch_count == 0) begin
         a.status = STATUS_EMPTY;
         empty_reads++;
      end else begin
         // ascending by packed pair; equal pairs are identical so stability is moot
         if (!batch_sorted) begin
            for (i = 1; i < batch_count; i++) begin
               v = batch_items[i];
               j = i;
               while (j > 0 && batch_items[j-1] > v) begin
                  batch_items[j] = batch_items[j-1];
                  j--;
               end
               batch_items[j] = v;
            end
            batch_sorted = 1'b1;
            read_index = 0;
            sorts_done++;
         end
         a.status = STATUS_READ_OK;
         {a.first_vertex_out, a.second_vertex_out} = batch_items[read_index];
         read_index++;
         if (read_index >= batch_count) begin
            a.last_item = 1'b1;
            batch_count = 0;
            read_index = 0;
            batch_sorted = 1'b0;
            batches_drained++;
         end
      end
      return a;
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return plan_limit;
      if (roll < 4 && plan_limit != KEY_LIMIT_RESET)
         return KEY_BITS'($urandom_range(int'(plan_limit) + 1, KEY_RANGE - 1));
      if (roll < 6)
         return KEY_BITS'($urandom);
      // narrow range gives plenty of duplicate keys
      if (roll < 9)
         return KEY_BITS'($urandom_range(0, (plan_limit < 7) ? int'(plan_limit) : 7));
      return KEY_BITS'($urandom_range(0, int'(plan_limit)));
   endfunction

   task automatic push_load(input logic [KEY_BITS-1:0] hi, input logic [KEY_BITS-1:0] lo);
      req_type r;
      r.action = ACT_LOAD;
      r.first_vertex = hi;
      r.second_vertex = lo;
      queued_requests.push_back(r);
      items_queued++;
      if (plan_count < CAPACITY && hi <= plan_limit && lo <= plan_limit) begin
         plan_count++;
         plan_ptr = 0;
      end
   endtask

   task automatic push_read();
      req_type r;
      r.action = ACT_READ;
      // key fields are don't-care on a read
      r.first_vertex = KEY_BITS'($urandom);
      r.second_vertex = KEY_BITS'($urandom);
      queued_requests.push_back(r);
      items_queued++;
      if (plan_count > 0) begin
         plan_ptr++;
         if (plan_ptr >= plan_count) begin
            plan_count = 0;
            plan_ptr = 0;
         end
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_answers.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // only called at a falling edge with the sorter idle
   task automatic write_limit(input logic [KEY_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      limit_now = value;
      plan_limit = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result check and prediction, sampled at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: unexpected rsp status %0d pair %0d %0d last %0b",
                           $time, rsp_data.status, rsp_data.first_vertex_out,
                           rsp_data.second_vertex_out, rsp_data.last_item);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.first_vertex_out !== want.first_vertex_out ||
                   rsp_data.second_vertex_out !== want.second_vertex_out ||
                   rsp_data.last_item !== want.last_item) begin
                  errors++;
                  if (errors <= 40)
                     $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                              $time, want.status, want.first_vertex_out,
                              want.second_vertex_out, want.last_item,
                              rsp_data.status, rsp_data.first_vertex_out,
                              rsp_data.second_vertex_out, rsp_data.last_item);
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_answers.push_back(sorter_answer(req_data));
            req_taken = 1'b1;
         end
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_requests.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= queued_requests.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: shifting stall patterns plus occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (answers_seen >= next_hold_at) begin
         hold_left = HOLD_CYCLES;
         next_hold_at += HOLD_SPACING;
         holds_done++;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:        rsp_ready <= (mode_left % 3 != 0);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int random_start;
      int rounds;
      int burst;
      int roll;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // read with nothing loaded, extreme keys, duplicates, reload mid readout
      push_read();
      push_load(10'd0, 10'd0);
      push_load(10'd1023, 10'd1023);
      push_load(10'd1023, 10'd0);
      push_load(10'd0, 10'd1023);
      push_load(10'd5, 10'd7);
      push_load(10'd5, 10'd7);
      push_load(10'd5, 10'd3);
      repeat (3) push_read();
      push_load(10'd512, 10'd512);
      while (plan_count > 0)
         push_read();
      push_read();
      wait_drained();

      // limit at zero, then mid value with keys one above it
      write_limit('0);
      push_load(10'd0, 10'd0);
      push_load(10'd1, 10'd0);
      push_load(10'd0, 10'd1);
      wait_drained();
      write_limit(10'd600);
      push_load(10'd600, 10'd600);
      push_load(10'd601, 10'd3);
      push_load(10'd3, 10'd601);
      wait_drained();
      // lowering the limit keeps items already stored
      write_limit(10'd100);
      while (plan_count > 0)
         push_read();
      wait_drained();

      random_start = items_queued;
      rounds = 0;
      while (items_queued - random_start < RANDOM_ITEMS) begin
         if (rounds % 6 == 0) begin
            wait_drained();
            roll = $urandom_range(0, 3);
            if (roll == 0)
               write_limit('0);
            else if (roll == 1)
               write_limit(KEY_LIMIT_RESET);
            else if (roll == 2)
               write_limit(KEY_BITS'($urandom));
            else
               write_limit(KEY_BITS'($urandom_range(900, KEY_RANGE - 1)));
         end
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
         repeat (burst)
            push_load(pick_key(), pick_key());
         if (plan_count > 0 && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, plan_count))
               push_read();
            push_load(pick_key(), pick_key());
         end
         // now and then a batch is left half read and grows in the next round
         while (plan_count > 0 && $urandom_range(0, 15) != 0)
            push_read();
         if ($urandom_range(0, 5) == 0)
            push_read();
         rounds++;
      end
      wait_drained();

      // fill to capacity, overflow, full check ahead of the key check
      write_limit(KEY_LIMIT_RESET);
      while (plan_count < CAPACITY)
         push_load(pick_key(), pick_key());
      push_load(pick_key(), pick_key());
      wait_drained();
      write_limit('0);
      push_load(10'd1023, 10'd1023);
      // the first reads sort the full batch
      repeat (TAIL_READS)
         push_read();
      wait_drained();

      repeat (20) @(posedge clock);
      $display("covered %0d loads stored, %0d full, %0d over limit, %0d empty reads",
               loads_stored, full_rejects, limit_rejects, empty_reads);
      $display("%0d limit writes, %0d sorts, %0d batches drained, %0d long hold-offs",
               csr_writes, sorts_done, batches_drained, holds_done);
      if (errors == 0 && awaited_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
